FILE: sv/sia_pkg.sv
// Shared constants, types and the output clamp for the small integer ALU.
`default_nettype none

package sia_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Word field widths
  localparam int FUNC_W   = 3;
  localparam int OPND_W   = 32;
  localparam int VAL_W    = 48;
  localparam int STATUS_W = 2;

  // Divider: |a| << FRAC_BITS over |b|
  localparam int QUO_W     = DATA_WIDTH + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(QUO_W + 1);

  // Root: one radicand bit pair per cycle
  localparam int SQ_PAIRS  = (DATA_WIDTH + 1) / 2 + FRAC_BITS;
  localparam int ROOT_W    = SQ_PAIRS;
  localparam int RAD_W     = 2 * SQ_PAIRS;
  localparam int SQ_REM_W  = SQ_PAIRS + 2;
  localparam int SQ_CNT_W  = $clog2(SQ_PAIRS + 1);

  // Power exponent width
  localparam int EXP_W = DATA_WIDTH - 1;

  // Pre-clamp result width, wide enough for a scaled word and a signed quotient
  localparam int SAT_W = (DATA_WIDTH + FRAC_BITS + 1 > VAL_W) ?
                         DATA_WIDTH + FRAC_BITS + 1 : VAL_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD  = 3'd0,
    FN_SUB  = 3'd1,
    FN_MUL  = 3'd2,
    FN_DIV  = 3'd3,
    FN_POW  = 3'd4,
    FN_ABS  = 3'd5,
    FN_SQRT = 3'd6
  } sia_func_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 2'd0,
    STS_DIV0     = 2'd1,
    STS_NEG_ROOT = 2'd2,
    STS_SAT      = 2'd3
  } sia_status_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             sat;
  } sia_sat_t;

  // Clamp a signed SAT_W value into the VAL_W range
  function automatic sia_sat_t sia_sat(input logic [SAT_W-1:0] v);
    sia_sat_t                 r;
    logic [SAT_W-VAL_W:0]     top;
    top = v[SAT_W-1:VAL_W-1];
    if ((&top) || !(|top)) begin
      r.value = v[VAL_W-1:0];
      r.sat   = 1'b0;
    end else if (v[SAT_W-1]) begin
      r.value = {1'b1, {(VAL_W-1){1'b0}}};
      r.sat   = 1'b1;
    end else begin
      r.value = {1'b0, {(VAL_W-1){1'b1}}};
      r.sat   = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/sia_if.sv
// Valid/ready channel interfaces for operand words and result words.
`default_nettype none

interface sia_in_if import sia_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [OPND_W-1:0] operand_a;
  logic signed [OPND_W-1:0] operand_b;

  modport source (output valid, output func, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input func, input operand_a, input operand_b,
                  output ready);
endinterface

interface sia_out_if import sia_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic [STATUS_W-1:0]     status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

FILE: sv/sia_mul.sv
// Bit-serial shift-add multiplier, product modulo 2^DATA_WIDTH.
`default_nettype none

module sia_mul import sia_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DATA_WIDTH-1:0] mcand,
  input  wire logic [DATA_WIDTH-1:0] mplier,
  output logic                       busy,
  output logic [DATA_WIDTH-1:0]      prod
);

  logic                  busy_r,   busy_nxt;
  logic [DATA_WIDTH-1:0] mcand_r,  mcand_nxt;
  logic [DATA_WIDTH-1:0] mplier_r, mplier_nxt;
  logic [DATA_WIDTH-1:0] prod_r,   prod_nxt;

  always_comb begin
    busy_nxt   = busy_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    prod_nxt   = prod_r;
    if (start) begin
      busy_nxt   = 1'b1;
      mcand_nxt  = mcand;
      mplier_nxt = mplier;
      prod_nxt   = '0;
    end else if (busy_r) begin
      // stop as soon as no multiplier bits remain
      if (mplier_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        if (mplier_r[0]) begin
          prod_nxt = prod_r + mcand_r;
        end
        mcand_nxt  = {mcand_r[DATA_WIDTH-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[DATA_WIDTH-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    prod_r   <= prod_nxt;
  end

  assign busy = busy_r;
  assign prod = prod_r;

endmodule

`default_nettype wire

FILE: sv/sia_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module sia_div import sia_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [QUO_W-1:0]      dividend,
  input  wire logic [DATA_WIDTH-1:0] divisor,
  output logic                       busy,
  output logic [QUO_W-1:0]           quo
);

  logic                  busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r,  cnt_nxt;
  logic [DATA_WIDTH-1:0] rem_r,  rem_nxt;
  logic [DATA_WIDTH-1:0] dsr_r,  dsr_nxt;
  logic [QUO_W-1:0]      q_r,    q_nxt;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;
  logic                  ge;

  // q_r shifts dividend bits out the top and quotient bits in the bottom
  assign trial = {rem_r, q_r[QUO_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = (trial >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(QUO_W);
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      q_nxt    = dividend;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
      q_nxt    = {q_r[QUO_W-2:0], ge};
      cnt_nxt  = cnt_r - DIV_CNT_W'(1);
      busy_nxt = (cnt_r != DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    q_r   <= q_nxt;
  end

  assign busy = busy_r;
  assign quo  = q_r;

endmodule

`default_nettype wire

FILE: sv/sia_sqrt.sv
// Digit-by-digit square root, one radicand bit pair per cycle.
`default_nettype none

module sia_sqrt import sia_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DATA_WIDTH-1:0] radicand,
  output logic                       busy,
  output logic [ROOT_W-1:0]          root
);

  logic                busy_r, busy_nxt;
  logic [SQ_CNT_W-1:0] cnt_r,  cnt_nxt;
  logic [RAD_W-1:0]    rad_r,  rad_nxt;
  logic [SQ_REM_W-1:0] rem_r,  rem_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic [SQ_REM_W-1:0] cur;
  logic [SQ_REM_W-1:0] trial;
  logic                ge;

  // rem stays below 2^SQ_PAIRS, so dropping its top two bits loses nothing
  assign cur   = {rem_r[SQ_REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial = {root_r, 2'b01};
  assign ge    = (cur >= trial);

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = SQ_CNT_W'(SQ_PAIRS);
      rad_nxt  = RAD_W'(radicand) << (2 * FRAC_BITS);
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
      rem_nxt  = ge ? (cur - trial) : cur;
      root_nxt = {root_r[ROOT_W-2:0], ge};
      cnt_nxt  = cnt_r - SQ_CNT_W'(1);
      busy_nxt = (cnt_r != SQ_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

`default_nettype wire

FILE: sv/small_integer_alu_unit.sv
// Small integer ALU: sequencer, serial arithmetic units and result register.
//
// Usage: one operand word (func, operand_a, operand_b) goes in on in_ch and
// one result word (value, status) comes out on out_ch, valid/ready on both.
// One word is in flight at a time; in_ch.ready is high while the sequencer
// is idle, also while a finished result still sits in the output register.
// Paths from accept to out_ch.valid:
//   add, sub, abs, power with exponent <= 0, divide by zero, negative root,
//   undefined code: straight to the done state, no arithmetic unit used
//   multiply: serial multiplier, runs until the highest set bit of operand_b is used
//   divide: the one-bit-per-cycle divider over 48 quotient bits
//   square root: the one-pair-per-cycle root over 32 pairs
//   power: one issue and wait round per exponent bit, a serial multiply (if the
//   bit is set) and square (if higher bits remain) running side by side per bit
// Reset (synchronous, rst_n low) idles the sequencer and empties the output
// register. If out_ch.ready stays low, the finished result waits in the
// output register; the next word may be taken and worked on, then waits in
// the done state until the output register frees.
`default_nettype none

module small_integer_alu_unit import sia_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  sia_in_if.sink    in_ch,
  sia_out_if.source out_ch
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_DONE  = 4'b1000
  } sia_state_t;

  sia_state_t            state_r, state_nxt;
  sia_func_t             func_r,  func_nxt;
  logic [DATA_WIDTH-1:0] a_r,     a_nxt;
  logic [DATA_WIDTH-1:0] b_r,     b_nxt;
  logic [DATA_WIDTH-1:0] acc_r,   acc_nxt;
  logic [DATA_WIDTH-1:0] base_r,  base_nxt;
  logic [EXP_W-1:0]      exp_r,   exp_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]      out_value_r;
  sia_status_t           out_status_r;
  logic                  out_load;

  sia_func_t             in_func;
  logic [DATA_WIDTH-1:0] in_a;
  logic [DATA_WIDTH-1:0] in_b;
  logic                  in_fire;

  logic                  m0_start, m1_start, div_start, sq_start;
  logic                  m0_busy,  m1_busy,  div_busy,  sq_busy;
  logic [DATA_WIDTH-1:0] m0_a, m0_b, m0_prod, m1_prod;
  logic [DATA_WIDTH-1:0] ua, ub;
  logic [QUO_W-1:0]      quo;
  logic [ROOT_W-1:0]     root;
  logic                  units_busy;

  logic [SAT_W-1:0]      scaled;
  logic [SAT_W-1:0]      quo_ext;
  logic [SAT_W-1:0]      quo_signed;
  sia_sat_t              sat_word;
  logic [VAL_W-1:0]      res_value;
  sia_status_t           res_status;

  assign in_func = sia_func_t'(in_ch.func);
  assign in_a    = in_ch.operand_a[DATA_WIDTH-1:0];
  assign in_b    = in_ch.operand_b[DATA_WIDTH-1:0];
  assign in_fire = in_ch.valid && in_ch.ready;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = out_value_r;
  assign out_ch.status = out_status_r;

  // ---------------------------------------------------------------- units
  assign m0_a = (func_r == FN_POW) ? acc_r  : a_r;
  assign m0_b = (func_r == FN_POW) ? base_r : b_r;
  assign ua   = a_r[DATA_WIDTH-1] ? -a_r : a_r;
  assign ub   = b_r[DATA_WIDTH-1] ? -b_r : b_r;

  sia_mul u_mul_acc (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (m0_start),
    .mcand  (m0_a),
    .mplier (m0_b),
    .busy   (m0_busy),
    .prod   (m0_prod)
  );

  sia_mul u_mul_sq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (m1_start),
    .mcand  (base_r),
    .mplier (base_r),
    .busy   (m1_busy),
    .prod   (m1_prod)
  );

  sia_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (QUO_W'(ua) << FRAC_BITS),
    .divisor  (ub),
    .busy     (div_busy),
    .quo      (quo)
  );

  sia_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (a_r),
    .busy     (sq_busy),
    .root     (root)
  );

  assign units_busy = m0_busy || m1_busy || div_busy || sq_busy;

  // ------------------------------------------------------------ sequencer
  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    exp_nxt   = exp_r;
    m0_start  = 1'b0;
    m1_start  = 1'b0;
    div_start = 1'b0;
    sq_start  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          func_nxt  = in_func;
          a_nxt     = in_a;
          b_nxt     = in_b;
          state_nxt = S_DONE;
          case (in_func)
            FN_ADD: acc_nxt = in_a + in_b;
            FN_SUB: acc_nxt = in_a - in_b;
            FN_ABS: acc_nxt = in_a[DATA_WIDTH-1] ? -in_a : in_a;
            FN_MUL: state_nxt = S_ISSUE;
            FN_DIV: begin
              if (in_b != '0) begin
                state_nxt = S_ISSUE;
              end
            end
            FN_POW: begin
              acc_nxt  = DATA_WIDTH'(1);
              base_nxt = in_a;
              exp_nxt  = in_b[EXP_W-1:0];
              if (!in_b[DATA_WIDTH-1] && (in_b != '0)) begin
                state_nxt = S_ISSUE;
              end
            end
            FN_SQRT: begin
              if (!in_a[DATA_WIDTH-1]) begin
                state_nxt = S_ISSUE;
              end
            end
            default: acc_nxt = acc_r;
          endcase
        end
      end
      S_ISSUE: begin
        m0_start  = (func_r == FN_MUL) || ((func_r == FN_POW) && exp_r[0]);
        // no square needed once the top exponent bit is consumed
        m1_start  = (func_r == FN_POW) && (exp_r[EXP_W-1:1] != '0);
        div_start = (func_r == FN_DIV);
        sq_start  = (func_r == FN_SQRT);
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (!units_busy) begin
          state_nxt = S_DONE;
          if (func_r == FN_MUL) begin
            acc_nxt = m0_prod;
          end else if (func_r == FN_POW) begin
            if (exp_r[0]) begin
              acc_nxt = m0_prod;
            end
            base_nxt = m1_prod;
            exp_nxt  = {1'b0, exp_r[EXP_W-1:1]};
            if (exp_r[EXP_W-1:1] != '0) begin
              state_nxt = S_ISSUE;
            end
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ------------------------------------------------------- result select
  assign scaled     = {{(SAT_W-DATA_WIDTH){acc_r[DATA_WIDTH-1]}}, acc_r} << FRAC_BITS;
  assign quo_ext    = SAT_W'(quo);
  assign quo_signed = (a_r[DATA_WIDTH-1] ^ b_r[DATA_WIDTH-1]) ? -quo_ext : quo_ext;

  always_comb begin
    sat_word   = sia_sat(scaled);
    res_value  = '0;
    res_status = STS_OK;
    case (func_r)
      FN_ADD, FN_SUB, FN_MUL, FN_POW, FN_ABS: begin
        res_value  = sat_word.value;
        res_status = sat_word.sat ? STS_SAT : STS_OK;
      end
      FN_DIV: begin
        if (b_r == '0) begin
          res_status = STS_DIV0;
        end else begin
          sat_word   = sia_sat(quo_signed);
          res_value  = sat_word.value;
          res_status = sat_word.sat ? STS_SAT : STS_OK;
        end
      end
      FN_SQRT: begin
        if (a_r[DATA_WIDTH-1]) begin
          res_status = STS_NEG_ROOT;
        end else begin
          sat_word   = sia_sat(SAT_W'(root));
          res_value  = sat_word.value;
          res_status = sat_word.sat ? STS_SAT : STS_OK;
        end
      end
      default: res_status = STS_OK;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ------------------------------------------------------------ registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    base_r <= base_nxt;
    exp_r  <= exp_nxt;
    if (out_load) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
    end
  end

  // ----------------------------------------------------------- assertions
  a_idle_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !units_busy)
    else $error("arithmetic unit busy while sequencer idle");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("sequencer stayed idle after taking a word");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (m0_start || m1_start || div_start || sq_start) |-> !units_busy)
    else $error("unit restarted while still busy");

  a_pow_exp_live: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_ISSUE) && (func_r == FN_POW)) |-> (exp_r != '0))
    else $error("power step issued with no exponent bits left");

endmodule

`default_nettype wire
